// ----- src/sstf_disk_scheduler_assert.svh -----
// assertion macros for the sstf disk scheduler
`ifndef SSTF_DISK_SCHEDULER_ASSERT_SVH
`define SSTF_DISK_SCHEDULER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SSTF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sstf assertion failed");

// next-cycle implication, disabled during reset
`define SSTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sstf assertion failed");

`endif

// ----- src/sstf_pkg.sv -----
// package with sizes and types for the sstf disk scheduler
`timescale 1ns / 1ps
package sstf_pkg;
	localparam int MAX_REQUESTS = 32;
	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
	localparam int TRK_W = 16;

	typedef enum logic [0:0] {
		FUNC_LOAD = 1'b0,
		FUNC_RUN  = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;
endpackage

// ----- src/sstf_if.sv -----
// valid/ready channel interfaces for requests and served tracks
`timescale 1ns / 1ps
interface sstf_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] request_track;
	logic [15:0] start_position;

	modport source (output valid, output func, output request_track,
		output start_position, input ready);
	modport sink (input valid, input func, input request_track,
		input start_position, output ready);
endinterface

interface sstf_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] served_track;
	logic        last;
	logic        overflow;

	modport source (output valid, output served_track, output last,
		output overflow, input ready);
	modport sink (input valid, input served_track, input last,
		input overflow, output ready);
endinterface

// ----- src/sstf_disk_scheduler.sv -----
// shortest-seek-time-first disk request scheduler, top level
// usage:
//   req channel: func 0 loads request_track into the next free table entry
//   (no result); a load into a full table is dropped and remembered.
//   func 1 sets the head to start_position and serves every stored request.
//   rsp channel: one transfer per served request, nearest unserved track first,
//   lowest table entry wins a tie; last marks the final transfer of a run and
//   overflow reports a dropped load since the previous run.
//   a run with n stored requests serves them one at a time: each result is one
//   pass of the shared distance compare over the table memory (one entry per
//   cycle, registered read) followed by an emit step, which waits on output stalls.
//   req.ready is high only between runs.
//   a finished result sits in the output register until rsp.ready; the
//   sequencer waits in its emit step while the receiver stalls.
//   after a run the table, served marks and overflow mark are empty again and
//   the head stays at the last served track.
//   reset empties the table and sets the head to zero; no clearing pass is needed.
`timescale 1ns / 1ps
`include "sstf_disk_scheduler_assert.svh"
module sstf_disk_scheduler
	import sstf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	sstf_in_if.sink    req,
	sstf_out_if.source rsp
);
	state_t                  state_q;
	logic [TRK_W-1:0]        store_mem [MAX_REQUESTS];
	logic [MAX_REQUESTS-1:0] served_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [TRK_W-1:0]        head_q;
	logic                    ovf_q;

	logic [CNT_W-1:0]        issue_q;
	logic [CNT_W-1:0]        round_q;
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic [TRK_W-1:0]        rd_trk_s1;

	logic                    found_q;
	logic [TRK_W-1:0]        best_span_q;
	logic [IDX_W-1:0]        best_idx_q;
	logic [TRK_W-1:0]        best_trk_q;

	logic                    out_vld_q;
	logic [TRK_W-1:0]        out_trk_q;
	logic                    out_last_q;
	logic                    out_ovf_q;

	logic                    in_fire;
	logic                    load_ok;
	logic                    issue_en;
	logic [TRK_W-1:0]        span;
	logic                    take;
	logic                    scan_end;
	logic                    out_free;
	logic                    emit_fire;
	logic                    round_last;

	assign req.ready = (state_q == ST_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign load_ok   = in_fire && (req.func == FUNC_LOAD) &&
		(cnt_q < CNT_W'(MAX_REQUESTS));
	assign issue_en  = (state_q == ST_SCAN) && (issue_q < cnt_q);

	// shared distance and compare unit
	assign span = (head_q >= rd_trk_s1) ? (head_q - rd_trk_s1) : (rd_trk_s1 - head_q);
	assign take = rd_vld_s1 && !served_q[rd_idx_s1] && (!found_q || (span < best_span_q));
	assign scan_end = rd_vld_s1 && (rd_idx_s1 == IDX_W'(cnt_q - CNT_W'(1)));

	assign out_free   = !out_vld_q || rsp.ready;
	assign emit_fire  = (state_q == ST_EMIT) && out_free;
	assign round_last = (round_q == (cnt_q - CNT_W'(1)));

	assign rsp.valid        = out_vld_q;
	assign rsp.served_track = out_trk_q;
	assign rsp.last         = out_last_q;
	assign rsp.overflow     = out_ovf_q;

	// table memory with registered read
	always_ff @(posedge clk) begin
		if (load_ok) begin
			store_mem[cnt_q[IDX_W-1:0]] <= req.request_track;
		end
		rd_trk_s1 <= store_mem[issue_q[IDX_W-1:0]];
		rd_idx_s1 <= issue_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			served_q  <= '0;
			cnt_q     <= '0;
			head_q    <= '0;
			ovf_q     <= 1'b0;
			issue_q   <= '0;
			round_q   <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue_en;
			out_vld_q <= emit_fire || (out_vld_q && !rsp.ready);
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (req.func == FUNC_LOAD) begin
							if (load_ok) begin
								cnt_q <= cnt_q + CNT_W'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end else begin
							head_q  <= req.start_position;
							issue_q <= '0;
							round_q <= '0;
							found_q <= 1'b0;
							if (cnt_q == '0) begin
								ovf_q <= 1'b0;
							end else begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					if (issue_en) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (take) begin
						found_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						head_q    <= best_trk_q;
						issue_q   <= '0;
						found_q   <= 1'b0;
						if (round_last) begin
							served_q <= '0;
							cnt_q    <= '0;
							ovf_q    <= 1'b0;
							state_q  <= ST_IDLE;
						end else begin
							served_q[best_idx_q] <= 1'b1;
							round_q  <= round_q + CNT_W'(1);
							state_q  <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// best candidate and output payload
	always_ff @(posedge clk) begin
		if (take) begin
			best_span_q <= span;
			best_idx_q  <= rd_idx_s1;
			best_trk_q  <= rd_trk_s1;
		end
		if (emit_fire) begin
			out_trk_q  <= best_trk_q;
			out_last_q <= round_last;
			out_ovf_q  <= ovf_q;
		end
	end

	`SSTF_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(MAX_REQUESTS))
	`SSTF_ASSERT_NOW(a_emit_found, clk, arst_n, state_q == ST_EMIT, found_q)
	`SSTF_ASSERT_NOW(a_served_bound, clk, arst_n, 1'b1, $countones(served_q) <= int'(cnt_q))
	`SSTF_ASSERT_NEXT(a_run_clears, clk, arst_n, emit_fire && round_last,
		(cnt_q == '0) && (served_q == '0) && !ovf_q && rsp.valid && rsp.last)
endmodule

// ----- bench/tb_sstf_disk_scheduler.sv -----
// testbench for the sstf disk scheduler: directed table, random load/run batches, self-checking
`timescale 1ns / 1ps
module tb_sstf_disk_scheduler;
	import sstf_pkg::*;

	typedef struct packed {
		logic [TRK_W-1:0] track;
		logic             last;
		logic             overflow;
	} served_t;

	typedef struct {
		func_t            func;
		logic [TRK_W-1:0] track;
		logic [TRK_W-1:0] start;
		int               n_typed;
		served_t          typed;
	} stim_row_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;
	typedef enum {TRK_SPREAD, TRK_CLUSTER, TRK_EDGES, TRK_NARROW} trk_style_t;

	localparam int RANDOM_ITEMS = 470;
	localparam int DIR_ROWS = 21;

	logic clk = 1'b0;
	logic arst_n;

	sstf_in_if  req_if ();
	sstf_out_if rsp_if ();

	sstf_disk_scheduler u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #5 clk = ~clk;

	// n_typed -1: expected transfers come from the scheduler model
	stim_row_t directed_rows [DIR_ROWS] = '{
		'{FUNC_RUN,  16'h0000, 16'h1234,  0, '0},
		'{FUNC_LOAD, 16'hFFFF, 16'h0000, -1, '0},
		'{FUNC_RUN,  16'h0000, 16'h0000,  1, '{16'hFFFF, 1'b1, 1'b0}},
		'{FUNC_LOAD, 16'h0000, 16'hFFFF, -1, '0},
		'{FUNC_RUN,  16'hFFFF, 16'hFFFF,  1, '{16'h0000, 1'b1, 1'b0}},
		'{FUNC_LOAD, 16'd100,  16'h0000, -1, '0},
		'{FUNC_LOAD, 16'd200,  16'h0000, -1, '0},
		'{FUNC_LOAD, 16'd150,  16'h0000, -1, '0},
		'{FUNC_RUN,  16'h0000, 16'd175,  -1, '0},
		'{FUNC_LOAD, 16'h0000, 16'h0000, -1, '0},
		'{FUNC_LOAD, 16'hFFFF, 16'h0000, -1, '0},
		'{FUNC_LOAD, 16'h8000, 16'h0000, -1, '0},
		'{FUNC_RUN,  16'h0000, 16'h7FFF, -1, '0},
		'{FUNC_LOAD, 16'd500,  16'h0000, -1, '0},
		'{FUNC_LOAD, 16'd500,  16'h0000, -1, '0},
		'{FUNC_LOAD, 16'd499,  16'h0000, -1, '0},
		'{FUNC_RUN,  16'h0000, 16'd500,  -1, '0},
		'{FUNC_RUN,  16'h0000, 16'h0000,  0, '0},
		'{FUNC_LOAD, 16'hAAAA, 16'h0000, -1, '0},
		'{FUNC_LOAD, 16'h5555, 16'h0000, -1, '0},
		'{FUNC_RUN,  16'h0000, 16'h8000, -1, '0}
	};

	// scheduler model state
	logic [TRK_W-1:0] pend_track [MAX_REQUESTS];
	int               pend_count;
	logic [TRK_W-1:0] head_trk;
	bit               drop_seen;
	served_t          run_out [$];

	served_t served_q [$];
	int      err_count;
	int      burst_left;
	int      items_sent;

	function automatic void schedule_item(input func_t f, input logic [TRK_W-1:0] trk,
			input logic [TRK_W-1:0] start);
		bit          done [MAX_REQUESTS];
		int          best_idx;
		int          best_span;
		int          span;
		run_out.delete();
		if (f == FUNC_LOAD) begin
			if (pend_count < MAX_REQUESTS) begin
				pend_track[pend_count] = trk;
				pend_count++;
			end else begin
				drop_seen = 1'b1;
			end
			return;
		end
		head_trk = start;
		foreach (done[k])
			done[k] = 1'b0;
		for (int r = 0; r < pend_count; r++) begin
			best_idx = -1;
			best_span = 0;
			for (int k = 0; k < pend_count; k++) begin
				if (!done[k]) begin
					span = (head_trk >= pend_track[k]) ? int'(head_trk) - int'(pend_track[k])
						: int'(pend_track[k]) - int'(head_trk);
					if (best_idx < 0 || span < best_span) begin
						best_idx = k;
						best_span = span;
					end
				end
			end
			done[best_idx] = 1'b1;
			head_trk = pend_track[best_idx];
			run_out.push_back('{head_trk, (r == pend_count - 1), drop_seen});
		end
		pend_count = 0;
		drop_seen = 1'b0;
	endfunction

	task automatic send_item(input func_t f, input logic [TRK_W-1:0] trk,
			input logic [TRK_W-1:0] start, input int n_typed, input served_t typed);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		req_if.valid          <= 1'b1;
		req_if.func           <= f;
		req_if.request_track  <= trk;
		req_if.start_position <= start;
		do @(posedge clk); while (!req_if.ready);
		// transfer taken at this edge
		schedule_item(f, trk, start);
		if (n_typed >= 0) begin
			if (n_typed > 0)
				served_q.push_back(typed);
		end else begin
			foreach (run_out[i])
				served_q.push_back(run_out[i]);
		end
		items_sent++;
	endtask

	function automatic logic [TRK_W-1:0] pick_track(input trk_style_t style,
			input logic [TRK_W-1:0] base);
		case (style)
			TRK_SPREAD:  return TRK_W'($urandom);
			TRK_CLUSTER: return base + TRK_W'($urandom_range(0, 8)) - TRK_W'(4);
			TRK_EDGES: begin
				case ($urandom_range(0, 2))
					0:       return '0;
					1:       return '1;
					default: return TRK_W'($urandom);
				endcase
			end
			default:     return TRK_W'($urandom_range(0, 15));
		endcase
	endfunction

	// receiver stall pattern
	initial begin
		rx_mode_t mode;
		int       span_len;
		int       phase;
		rsp_if.ready <= 1'b0;
		phase = 0;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span_len = $urandom_range(20, 300);
			repeat (span_len) begin
				@(posedge clk);
				phase++;
				case (mode)
					RX_OPEN:     rsp_if.ready <= 1'b1;
					RX_COIN:     rsp_if.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE:   rsp_if.ready <= ($urandom_range(0, 3) == 0);
					RX_PERIODIC: rsp_if.ready <= ((phase % 7) > 2);
					default:     rsp_if.ready <= 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		served_t exp_res;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (served_q.size() == 0) begin
				$error("unexpected transfer: served_track %0d last %0b overflow %0b",
					rsp_if.served_track, rsp_if.last, rsp_if.overflow);
				err_count++;
			end else begin
				exp_res = served_q.pop_front();
				if (rsp_if.served_track !== exp_res.track) begin
					$error("served_track: expected %0d, got %0d", exp_res.track,
						rsp_if.served_track);
					err_count++;
				end
				if (rsp_if.last !== exp_res.last) begin
					$error("last: expected %0b, got %0b", exp_res.last, rsp_if.last);
					err_count++;
				end
				if (rsp_if.overflow !== exp_res.overflow) begin
					$error("overflow: expected %0b, got %0b", exp_res.overflow,
						rsp_if.overflow);
					err_count++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int               n_loads;
		trk_style_t       style;
		logic [TRK_W-1:0] base;
		logic [TRK_W-1:0] start;
		pend_count = 0;
		head_trk = '0;
		drop_seen = 1'b0;
		err_count = 0;
		burst_left = 0;
		items_sent = 0;
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.func <= FUNC_LOAD;
		req_if.request_track <= '0;
		req_if.start_position <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].func, directed_rows[i].track, directed_rows[i].start,
				directed_rows[i].n_typed, directed_rows[i].typed);

		while (items_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       n_loads = 0;
				1:       n_loads = MAX_REQUESTS;
				2:       n_loads = MAX_REQUESTS + $urandom_range(1, 4);
				default: n_loads = $urandom_range(1, 10);
			endcase
			style = trk_style_t'($urandom_range(0, 3));
			base = TRK_W'($urandom);
			repeat (n_loads)
				send_item(FUNC_LOAD, pick_track(style, base), TRK_W'($urandom), -1, '0);
			// now and then the run is left out so loads pile up into the next batch
			if ($urandom_range(0, 4) != 0) begin
				case ($urandom_range(0, 3))
					0:       start = pick_track(TRK_EDGES, base);
					1:       start = base;
					default: start = TRK_W'($urandom);
				endcase
				send_item(FUNC_RUN, TRK_W'($urandom), start, -1, '0);
			end
		end
		send_item(FUNC_RUN, TRK_W'($urandom), TRK_W'($urandom), -1, '0);
		req_if.valid <= 1'b0;

		while (served_q.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
